@@ src/erbid_pkg.sv @@
// package for the escape-rle bitplane image decoder
// transaction structs, request and status codes, controller commands and states
// no dependencies
`timescale 1ns / 1ps

package erbid_pkg;

    localparam logic [1:0] REQ_PAL_WRITE  = 2'd0;
    localparam logic [1:0] REQ_DATA_BYTE  = 2'd1;
    localparam logic [1:0] REQ_PIXEL_READ = 2'd2;
    localparam logic [1:0] REQ_NEW_IMAGE  = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_ERROR   = 2'd1;
    localparam logic [1:0] STATUS_PENDING = 2'd2;

    localparam logic [7:0] ESC_BYTE     = 8'h01;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] pal_index;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] data_byte;
        logic       data_last;
        logic [9:0] pixel_x;
        logic [8:0] pixel_y;
    } in_item_t;

    typedef struct packed {
        logic [3:0] color_index;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic [1:0] status;
    } out_item_t;

    typedef enum logic [1:0] {
        PH_PLAIN,
        PH_VALUE,
        PH_COUNT
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_FETCH,
        ST_GATHER,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic pal_write;
        logic byte_take;
        logic new_image;
        logic read_start;
        logic run_step;
        logic mem_read;
        logic pal_read;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic run_start;
        logic run_done;
        logic out_free;
    } stat_t;

endpackage

@@ src/erbid_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module erbid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/erbid_ctrl.sv @@
// controller state machine of the bitplane image decoder
// depends on erbid_pkg
`timescale 1ns / 1ps

module erbid_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        req_type,
    output logic              in_ready,
    input  erbid_pkg::stat_t  stat,
    output erbid_pkg::cmd_t   cmd
);

    erbid_pkg::ctrl_state_t state_reg;
    erbid_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= erbid_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            erbid_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (req_type)
                        erbid_pkg::REQ_PAL_WRITE:
                        begin
                            cmd.pal_write = 1'b1;
                        end
                        erbid_pkg::REQ_DATA_BYTE:
                        begin
                            cmd.byte_take = 1'b1;
                            if (stat.run_start)
                            begin
                                state_next = erbid_pkg::ST_RUN;
                            end
                        end
                        erbid_pkg::REQ_PIXEL_READ:
                        begin
                            cmd.read_start = 1'b1;
                            state_next     = erbid_pkg::ST_FETCH;
                        end
                        default:
                        begin
                            cmd.new_image = 1'b1;
                        end
                    endcase
                end
            end
            erbid_pkg::ST_RUN:
            begin
                cmd.run_step = 1'b1;
                if (stat.run_done)
                begin
                    state_next = erbid_pkg::ST_IDLE;
                end
            end
            erbid_pkg::ST_FETCH:
            begin
                cmd.mem_read = 1'b1;
                state_next   = erbid_pkg::ST_GATHER;
            end
            erbid_pkg::ST_GATHER:
            begin
                cmd.pal_read = 1'b1;
                state_next   = erbid_pkg::ST_EMIT;
            end
            erbid_pkg::ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = erbid_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = erbid_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/erbid_datapath.sv @@
// datapath of the bitplane image decoder: run decoder, plane and palette memories,
// pixel gather and output register
// depends on erbid_pkg and erbid_ram
`timescale 1ns / 1ps

module erbid_datapath #(
    parameter int ROW_BYTES   = 80,
    parameter int ROWS        = 480,
    parameter int PLANE_COUNT = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  erbid_pkg::in_item_t  in_data,
    input  erbid_pkg::cmd_t      cmd,
    output erbid_pkg::stat_t     stat,
    input  logic                 out_ready,
    output logic                 out_valid,
    output erbid_pkg::out_item_t out_data
);

    localparam int PLANE_BYTES = ROW_BYTES * ROWS;
    localparam int AW          = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;
    localparam int PW          = $clog2(PLANE_COUNT + 1);
    localparam int X_MAX       = ROW_BYTES * 8 - 1;
    localparam int Y_MAX       = ROWS - 1;
    localparam int OFF_W       = 20;

    erbid_pkg::phase_t phase_reg;
    erbid_pkg::phase_t phase_next;
    logic [7:0]        run_value_reg;
    logic [7:0]        run_value_next;
    logic [7:0]        run_cnt_reg;
    logic [7:0]        run_cnt_next;
    logic              last_reg;
    logic              last_next;
    logic [PW-1:0]     plane_reg;
    logic [PW-1:0]     plane_next;
    logic [AW-1:0]     pos_reg;
    logic [AW-1:0]     pos_next;
    logic              err_reg;
    logic              err_next;

    logic              full;
    logic              pos_last;
    logic [AW-1:0]     pos_adv;
    logic [PW-1:0]     plane_adv;
    logic              put_plain;
    logic              wr_en;
    logic [7:0]        wr_data;

    logic [10:0]       x_ext;
    logic [10:0]       x_sat;
    logic [9:0]        y_ext;
    logic [9:0]        y_sat;
    logic [OFF_W-1:0]  off_full;
    logic [1:0]        status_now;

    logic [AW-1:0]     off_reg;
    logic [2:0]        sh_reg;
    logic [1:0]        stat_reg;
    logic [7:0]        color_reg;
    logic [PLANE_COUNT-1:0] color_bits;
    logic [7:0]        plane_rdata [PLANE_COUNT];
    logic [23:0]       pal_rdata;

    erbid_pkg::out_item_t out_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              ok;

    // run and plane bookkeeping
    always_comb
    begin
        full      = (plane_reg == PW'(PLANE_COUNT));
        pos_last  = (pos_reg == AW'(PLANE_BYTES - 1));
        pos_adv   = pos_last ? '0 : pos_reg + 1'b1;
        plane_adv = pos_last ? plane_reg + 1'b1 : plane_reg;
        put_plain = cmd.byte_take && !full && (phase_reg == erbid_pkg::PH_PLAIN)
                    && (in_data.data_byte != erbid_pkg::ESC_BYTE);
        wr_en     = put_plain || cmd.run_step;
        wr_data   = cmd.run_step ? run_value_reg : in_data.data_byte;

        stat.run_start = !full && (phase_reg == erbid_pkg::PH_COUNT)
                         && (in_data.data_byte != 8'd0);
        stat.run_done  = (run_cnt_reg == 8'd1) || pos_last;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        run_value_next = run_value_reg;
        run_cnt_next   = run_cnt_reg;
        last_next      = last_reg;
        plane_next     = plane_reg;
        pos_next       = pos_reg;
        err_next       = err_reg;
        if (cmd.new_image)
        begin
            phase_next     = erbid_pkg::PH_PLAIN;
            run_value_next = 8'd0;
            plane_next     = '0;
            pos_next       = '0;
            err_next       = 1'b0;
        end
        else if (cmd.byte_take)
        begin
            if (full)
            begin
                phase_next = erbid_pkg::PH_PLAIN;
            end
            else
            begin
                case (phase_reg)
                    erbid_pkg::PH_PLAIN:
                    begin
                        if (in_data.data_byte == erbid_pkg::ESC_BYTE)
                        begin
                            phase_next = erbid_pkg::PH_VALUE;
                        end
                        else
                        begin
                            pos_next   = pos_adv;
                            plane_next = plane_adv;
                        end
                    end
                    erbid_pkg::PH_VALUE:
                    begin
                        run_value_next = in_data.data_byte;
                        phase_next     = erbid_pkg::PH_COUNT;
                    end
                    default:
                    begin
                        phase_next   = erbid_pkg::PH_PLAIN;
                        run_cnt_next = in_data.data_byte;
                        last_next    = in_data.data_last;
                    end
                endcase
            end
            if (in_data.data_last && !stat.run_start
                && ((phase_next != erbid_pkg::PH_PLAIN) || (plane_next != PW'(PLANE_COUNT))))
            begin
                err_next = 1'b1;
            end
        end
        else if (cmd.run_step)
        begin
            pos_next     = pos_adv;
            plane_next   = plane_adv;
            run_cnt_next = run_cnt_reg - 8'd1;
            if (stat.run_done && last_reg && (plane_adv != PW'(PLANE_COUNT)))
            begin
                err_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= erbid_pkg::PH_PLAIN;
            plane_reg     <= '0;
            pos_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            plane_reg     <= plane_next;
            pos_reg       <= pos_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_value_reg <= run_value_next;
        run_cnt_reg   <= run_cnt_next;
        last_reg      <= last_next;
    end

    // pixel address
    always_comb
    begin
        x_ext      = 11'(in_data.pixel_x);
        x_sat      = (x_ext > 11'(X_MAX)) ? 11'(X_MAX) : x_ext;
        y_ext      = 10'(in_data.pixel_y);
        y_sat      = (y_ext > 10'(Y_MAX)) ? 10'(Y_MAX) : y_ext;
        off_full   = OFF_W'(y_sat) * OFF_W'(ROW_BYTES) + OFF_W'(x_sat[10:3]);
        status_now = err_reg ? erbid_pkg::STATUS_ERROR
                   : (full ? erbid_pkg::STATUS_OK : erbid_pkg::STATUS_PENDING);
    end

    generate
        for (genvar p = 0; p < PLANE_COUNT; p++)
        begin : g_plane
            erbid_ram #(
                .WIDTH (8),
                .DEPTH (PLANE_BYTES)
            ) u_plane_ram (
                .clk   (clk),
                .we    (wr_en && (plane_reg == PW'(p))),
                .waddr (pos_reg),
                .wdata (wr_data),
                .re    (cmd.mem_read),
                .raddr (off_reg),
                .rdata (plane_rdata[p])
            );
            assign color_bits[p] = plane_rdata[p][sh_reg];
        end
    endgenerate

    erbid_ram #(
        .WIDTH (24),
        .DEPTH (256)
    ) u_palette_ram (
        .clk   (clk),
        .we    (cmd.pal_write),
        .waddr (in_data.pal_index),
        .wdata ({in_data.red_in, in_data.green_in, in_data.blue_in}),
        .re    (cmd.pal_read),
        .raddr (8'(color_bits)),
        .rdata (pal_rdata)
    );

    assign ok             = (stat_reg == erbid_pkg::STATUS_OK);
    assign out_valid_next = cmd.out_load | (out_valid_reg & ~out_ready);

    always_ff @(posedge clk)
    begin
        if (cmd.read_start)
        begin
            off_reg  <= off_full[AW-1:0];
            sh_reg   <= ~x_sat[2:0];
            stat_reg <= status_now;
        end
        if (cmd.pal_read)
        begin
            color_reg <= 8'(color_bits);
        end
        if (cmd.out_load)
        begin
            out_reg.color_index <= ok ? color_reg[3:0] : 4'd0;
            out_reg.red_out     <= ok ? pal_rdata[23:16] : 8'd0;
            out_reg.green_out   <= ok ? pal_rdata[15:8] : 8'd0;
            out_reg.blue_out    <= ok ? pal_rdata[7:0] : 8'd0;
            out_reg.alpha_out   <= erbid_pkg::ALPHA_OPAQUE;
            out_reg.status      <= stat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ src/escape_rle_bitplane_image_decoder.sv @@
// top level of the escape-rle bitplane image decoder
// depends on erbid_pkg, erbid_ctrl and erbid_datapath
`timescale 1ns / 1ps

// Decodes an escape-RLE stream into PLANE_COUNT bitplanes held in one RAM per
// plane and answers pixel reads with the gathered colour index and its palette
// entry. Palette writes, begin-new-image, plain bytes and escape or value bytes
// are each taken in the idle state. A count byte of n writes the run one byte
// per cycle through the single write port of the plane memory, stopping early
// when the run is clipped at the end of a plane; no new item is taken until the
// run is done. A pixel read steps through offset multiply, plane memory read,
// palette read and output register, waiting for the output register to be free;
// a finished result held downstream does not block other kinds of transaction.
// The stores come out of reset with undefined contents and need no clearing pass.

module escape_rle_bitplane_image_decoder #(
    parameter int ROW_BYTES   = 80,
    parameter int ROWS        = 480,
    parameter int PLANE_COUNT = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  erbid_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output erbid_pkg::out_item_t out_data
);

    erbid_pkg::cmd_t  cmd;
    erbid_pkg::stat_t stat;

    erbid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (in_data.req_type),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    erbid_datapath #(
        .ROW_BYTES   (ROW_BYTES),
        .ROWS        (ROWS),
        .PLANE_COUNT (PLANE_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

@@ src/erbid_checker.sv @@
// port-level checker for the bitplane image decoder, bound to the top level
// depends on erbid_pkg and escape_rle_bitplane_image_decoder
`timescale 1ns / 1ps

module erbid_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input erbid_pkg::in_item_t  in_data,
    input logic                 out_valid,
    input logic                 out_ready,
    input erbid_pkg::out_item_t out_data
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.alpha_out == erbid_pkg::ALPHA_OPAQUE)
        else $error("alpha not opaque");

    // no pixel data leaks out of an unfinished or failed image
    a_masked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != erbid_pkg::STATUS_OK
        |-> out_data.color_index == 4'd0 && out_data.red_out == 8'd0
            && out_data.green_out == 8'd0 && out_data.blue_out == 8'd0)
        else $error("colour on a non-ok result");

    // a pixel read occupies the block for the following cycle
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.req_type == erbid_pkg::REQ_PIXEL_READ
        |=> !in_ready)
        else $error("transaction taken during a pixel read");

endmodule

bind escape_rle_bitplane_image_decoder erbid_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

@@ tb/tb_top.sv @@
// self-checking testbench for escape_rle_bitplane_image_decoder
// drives palette writes, compressed bytes, pixel reads and image restarts; checks pixel results
// depends on erbid_pkg and escape_rle_bitplane_image_decoder
`timescale 1ns / 1ps

module tb_top;

    localparam int ROW_BYTES   = 80;
    localparam int ROWS        = 480;
    localparam int PLANE_COUNT = 4;
    localparam int PLANE_BYTES = ROW_BYTES * ROWS;
    localparam int TAIL_ITEMS  = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    erbid_pkg::in_item_t  in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    erbid_pkg::out_item_t out_data;

    erbid_pkg::in_item_t  requests_todo[$];
    erbid_pkg::out_item_t pixels_due[$];
    int          fail_count = 0;
    bit          quiet_tail = 1'b0;

    // decoder state as seen from outside
    erbid_pkg::phase_t dec_phase = erbid_pkg::PH_PLAIN;
    logic [7:0]  run_val = 8'h00;
    int          plane_no = 0;
    int          byte_pos = 0;
    bit          sticky_err = 1'b0;
    logic [7:0]  plane_mem [PLANE_COUNT * PLANE_BYTES];
    logic [23:0] pal_mem [256];

    // stream position while building the stimulus
    int          fill_plane = 0;
    int          fill_pos = 0;

    bit                   has_pixel;
    erbid_pkg::out_item_t pixel;
    int          gap_left = 0;
    int          idle_pct = 0;
    int          drv_cycles = 0;
    int          stall_left = 0;
    int          stall_pct = 0;
    int          mon_cycles = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          quiet_cycles = 0;

    escape_rle_bitplane_image_decoder #(
        .ROW_BYTES   (ROW_BYTES),
        .ROWS        (ROWS),
        .PLANE_COUNT (PLANE_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic void store_byte(logic [7:0] v);
        if (plane_no >= PLANE_COUNT)
            return;
        plane_mem[plane_no * PLANE_BYTES + byte_pos] = v;
        byte_pos++;
        if (byte_pos >= PLANE_BYTES)
        begin
            byte_pos = 0;
            plane_no++;
            dec_phase = erbid_pkg::PH_PLAIN;
        end
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        int start_plane;
        int n;
        if (plane_no >= PLANE_COUNT)
        begin
            dec_phase = erbid_pkg::PH_PLAIN;
            return;
        end
        case (dec_phase)
            erbid_pkg::PH_PLAIN:
                if (b == erbid_pkg::ESC_BYTE)
                    dec_phase = erbid_pkg::PH_VALUE;
                else
                    store_byte(b);
            erbid_pkg::PH_VALUE:
            begin
                run_val = b;
                dec_phase = erbid_pkg::PH_COUNT;
            end
            default:
            begin
                start_plane = plane_no;
                n = int'(b);
                dec_phase = erbid_pkg::PH_PLAIN;
                while (n > 0 && plane_no == start_plane)
                begin
                    store_byte(run_val);
                    n--;
                end
            end
        endcase
    endfunction

    function automatic void decode_request(input erbid_pkg::in_item_t it, output bit has,
                                           output erbid_pkg::out_item_t res);
        int x;
        int y;
        int off;
        int sh;
        logic [7:0] idx;
        has = 1'b0;
        res = '0;
        case (it.req_type)
            erbid_pkg::REQ_PAL_WRITE:
                pal_mem[it.pal_index] = {it.red_in, it.green_in, it.blue_in};
            erbid_pkg::REQ_DATA_BYTE:
            begin
                decode_byte(it.data_byte);
                if (it.data_last
                    && (dec_phase != erbid_pkg::PH_PLAIN || plane_no < PLANE_COUNT))
                    sticky_err = 1'b1;
            end
            erbid_pkg::REQ_NEW_IMAGE:
            begin
                dec_phase = erbid_pkg::PH_PLAIN;
                run_val = 8'h00;
                plane_no = 0;
                byte_pos = 0;
                sticky_err = 1'b0;
            end
            default:
            begin
                x = int'(it.pixel_x);
                y = int'(it.pixel_y);
                if (x > ROW_BYTES * 8 - 1)
                    x = ROW_BYTES * 8 - 1;
                if (y > ROWS - 1)
                    y = ROWS - 1;
                res.alpha_out = erbid_pkg::ALPHA_OPAQUE;
                if (sticky_err)
                    res.status = erbid_pkg::STATUS_ERROR;
                else if (plane_no < PLANE_COUNT)
                    res.status = erbid_pkg::STATUS_PENDING;
                else
                begin
                    res.status = erbid_pkg::STATUS_OK;
                    off = y * ROW_BYTES + x / 8;
                    sh = 7 - x % 8;
                    idx = 8'h00;
                    for (int p = 0; p < PLANE_COUNT; p++)
                        idx[p] = plane_mem[p * PLANE_BYTES + off][sh];
                    res.color_index = idx[3:0];
                    {res.red_out, res.green_out, res.blue_out} = pal_mem[idx];
                end
                has = 1'b1;
            end
        endcase
    endfunction

    function automatic erbid_pkg::in_item_t random_item(logic [1:0] kind);
        logic [63:0] noise;
        erbid_pkg::in_item_t it;
        noise = {$urandom, $urandom};
        it = noise[61:0];
        it.req_type = kind;
        return it;
    endfunction

    function automatic void push_pal(logic [7:0] idx, logic [23:0] rgb);
        erbid_pkg::in_item_t it;
        it = random_item(erbid_pkg::REQ_PAL_WRITE);
        it.pal_index = idx;
        {it.red_in, it.green_in, it.blue_in} = rgb;
        requests_todo.push_back(it);
    endfunction

    function automatic void push_byte(logic [7:0] b, logic last);
        erbid_pkg::in_item_t it;
        it = random_item(erbid_pkg::REQ_DATA_BYTE);
        it.data_byte = b;
        it.data_last = last;
        requests_todo.push_back(it);
    endfunction

    function automatic void push_run(logic [7:0] v, logic [7:0] n, logic last);
        push_byte(erbid_pkg::ESC_BYTE, 1'b0);
        push_byte(v, 1'b0);
        push_byte(n, last);
    endfunction

    function automatic void push_read(int x, int y);
        erbid_pkg::in_item_t it;
        it = random_item(erbid_pkg::REQ_PIXEL_READ);
        it.pixel_x = x[9:0];
        it.pixel_y = y[8:0];
        requests_todo.push_back(it);
    endfunction

    function automatic void push_random_read();
        if ($urandom_range(99) < 80)
            push_read($urandom_range(ROW_BYTES * 8 - 1), $urandom_range(ROWS - 1));
        else
            push_read($urandom_range(1023), $urandom_range(511));
    endfunction

    function automatic void push_new();
        requests_todo.push_back(random_item(erbid_pkg::REQ_NEW_IMAGE));
    endfunction

    function automatic void fill_advance(int n);
        int w;
        w = (n < PLANE_BYTES - fill_pos) ? n : PLANE_BYTES - fill_pos;
        fill_pos += w;
        if (fill_pos == PLANE_BYTES)
        begin
            fill_pos = 0;
            fill_plane++;
        end
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    initial
    begin : stimulus
        int pick;
        int cnt;
        logic [7:0] val;

        // extremes and the special cases first
        push_pal(8'd0, 24'hFF00FF);
        push_pal(8'd255, 24'h00FF00);
        push_read(0, 0);
        push_read(1023, 511);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_run(erbid_pkg::ESC_BYTE, 8'd0, 1'b0);
        push_run(8'hA5, 8'd3, 1'b0);
        push_byte(erbid_pkg::ESC_BYTE, 1'b0);
        push_byte(8'h3C, 1'b1);
        push_read(639, 479);
        push_byte(8'h02, 1'b0);
        push_read(100, 200);
        push_new();
        push_read(639, 479);
        push_byte(8'h77, 1'b1);
        push_read(0, 479);
        push_new();

        for (int i = 0; i < 16; i++)
            push_pal(i[7:0], 24'($urandom));

        // one full image, mostly long runs, clipped at each plane end
        while (fill_plane < PLANE_COUNT)
        begin
            pick = $urandom_range(99);
            if (pick < 97)
            begin
                val = ($urandom_range(19) == 0) ? erbid_pkg::ESC_BYTE : 8'($urandom);
                pick = $urandom_range(99);
                cnt = (pick < 97) ? 255 : (pick < 99) ? $urandom_range(1, 254) : 0;
                fill_advance(cnt);
                push_run(val, cnt[7:0], fill_plane == PLANE_COUNT);
            end
            else if (pick < 98)
            begin
                val = 8'($urandom);
                if (val == erbid_pkg::ESC_BYTE)
                    val = 8'h81;
                fill_advance(1);
                push_byte(val, fill_plane == PLANE_COUNT);
            end
            else if (pick < 99)
                push_random_read();
            else
                push_pal(8'($urandom), 24'($urandom));
        end

        // complete image: reads, palette updates, stray bytes that are ignored
        repeat (50)
        begin
            pick = $urandom_range(99);
            if (pick < 85)
                push_random_read();
            else if (pick < 93)
                push_pal(8'($urandom), 24'($urandom));
            else
                push_byte(8'($urandom), 1'($urandom_range(1)));
        end

        // new image with broken streams, early last bytes and restarts
        push_new();
        repeat (50)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                push_run(8'($urandom), 8'($urandom_range(40)), 1'b0);
            else if (pick < 70)
                push_byte(8'($urandom), 1'b0);
            else if (pick < 88)
                push_random_read();
            else if (pick < 94)
                push_byte(8'($urandom), 1'b1);
            else if (pick < 97)
                push_new();
            else
                push_pal(8'($urandom), 24'($urandom));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_todo.size() != 0 || in_valid || pixels_due.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (fail_count == 0)
            $display("escape_rle_bitplane_image_decoder: match");
        else
            $display("escape_rle_bitplane_image_decoder: mismatch");
        $finish;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                decode_request(in_data, has_pixel, pixel);
                if (has_pixel)
                    pixels_due.push_back(pixel);
            end
            quiet_tail = requests_todo.size() < TAIL_ITEMS;
            drv_cycles++;
            if (drv_cycles % 97 == 0)
                case ($urandom_range(2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 8;
                    default: idle_pct = 35;
                endcase
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (requests_todo.size() == 0)
                    in_valid <= 1'b0;
                else if (!quiet_tail && $urandom_range(99) < idle_pct)
                begin
                    gap_left = $urandom_range(12);
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_data <= requests_todo.pop_front();
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // pixel result monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pixels_due.size() == 0)
                begin
                    $display("%0t: pixel result expected none got %p", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    pixel = pixels_due.pop_front();
                    check_field("color_index", 8'(pixel.color_index),
                                8'(out_data.color_index));
                    check_field("red_out", pixel.red_out, out_data.red_out);
                    check_field("green_out", pixel.green_out, out_data.green_out);
                    check_field("blue_out", pixel.blue_out, out_data.blue_out);
                    check_field("alpha_out", pixel.alpha_out, out_data.alpha_out);
                    check_field("status", 8'(pixel.status), 8'(out_data.status));
                end
            end
            mon_cycles++;
            if (mon_cycles % 89 == 0)
                case ($urandom_range(2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 4;
                    default: stall_pct = 20;
                endcase
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            // long hold-off once the reads of a complete image start to flow
            else if (!hold_done && out_valid && out_data.status == erbid_pkg::STATUS_OK)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(99) < stall_pct)
            begin
                stall_left = $urandom_range(12);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("escape_rle_bitplane_image_decoder: mismatch");
                    $finish;
                end
            end
        end
    end

endmodule

@@ sim.f @@
src/erbid_pkg.sv
src/erbid_ram.sv
src/erbid_ctrl.sv
src/erbid_datapath.sv
src/escape_rle_bitplane_image_decoder.sv
src/erbid_checker.sv
tb/tb_top.sv
